@@ hw/rtl/gmd_pkg.sv @@
package gmd_pkg;

  // Smallest grid dimension a solve will use
  localparam int unsigned MIN_DIM = 3;

  // Configuration register indexes and reset values
  localparam int unsigned REG_HEIGHT   = 0;
  localparam int unsigned REG_WIDTH    = 1;
  localparam int unsigned HEIGHT_RESET = 21;
  localparam int unsigned WIDTH_RESET  = 41;
  localparam int unsigned CFG_BITS     = 7;

  // Command codes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_SOLVE = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FOUND  = 2'd1,
    ST_NOPATH = 2'd2
  } status_e;

  // Cell marks held in the cell store
  typedef enum logic [2:0] {
    MK_OPEN = 3'd0,
    MK_WALL = 3'd1,
    MK_PATH = 3'd2,
    MK_ENTR = 3'd3,
    MK_DEAD = 3'd4
  } mark_e;

  // Neighbor probe order
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_e;

  // Commands to the coordinate stack
  typedef struct packed {
    logic init;  // reset to a single entry (the entrance)
    logic push;  // write at depth, depth + 1
    logic pop;   // depth - 1, read the new top
  } stk_cmd_t;

endpackage

@@ hw/rtl/gmd_nbr_step.sv @@
module gmd_nbr_step #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic [$clog2(MAX_ROWS)-1:0]   cur_row_i,
  input  logic [$clog2(MAX_COLS)-1:0]   cur_col_i,
  input  gmd_pkg::dir_e                 dir_i,
  input  logic [$clog2(MAX_ROWS+1)-1:0] height_i,
  input  logic [$clog2(MAX_COLS+1)-1:0] width_i,
  output logic [$clog2(MAX_ROWS)-1:0]   nb_row_o,
  output logic [$clog2(MAX_COLS)-1:0]   nb_col_o,
  output logic                          nb_ok_o
);

  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned CW = $clog2(MAX_COLS);

  // One step of the shared coordinate unit: neighbor position and in-grid test
  always_comb begin
    nb_row_o = cur_row_i;
    nb_col_o = cur_col_i;
    nb_ok_o  = 1'b0;
    unique case (dir_i)
      gmd_pkg::DIR_UP: begin
        nb_row_o = cur_row_i - RW'(1);
        nb_ok_o  = (cur_row_i != '0);
      end
      gmd_pkg::DIR_RIGHT: begin
        nb_col_o = cur_col_i + CW'(1);
        nb_ok_o  = ((CW+1)'(cur_col_i) + (CW+1)'(1)) < (CW+1)'(width_i);
      end
      gmd_pkg::DIR_DOWN: begin
        nb_row_o = cur_row_i + RW'(1);
        nb_ok_o  = ((RW+1)'(cur_row_i) + (RW+1)'(1)) < (RW+1)'(height_i);
      end
      gmd_pkg::DIR_LEFT: begin
        nb_col_o = cur_col_i - CW'(1);
        nb_ok_o  = (cur_col_i != '0);
      end
    endcase
  end

endmodule

@@ hw/rtl/gmd_cell_store.sv @@
module gmd_cell_store #(
  parameter int unsigned AW = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [2:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [2:0]    rdata_o
);

  logic [2:0] mem [2**AW];
  logic [2:0] rdata_q;

  // One write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/gmd_path_stack.sv @@
module gmd_path_stack #(
  parameter int unsigned AW = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gmd_pkg::stk_cmd_t cmd_i,
  input  logic [AW-1:0]     wdata_i,
  output logic [AW-1:0]     rdata_o,
  output logic [AW:0]       depth_o
);

  logic [AW-1:0] mem [2**AW];
  logic [AW-1:0] rdata_q;
  logic [AW:0]   depth_q;
  logic [AW-1:0] rd_addr;

  // On a pop the new top sits two below the current depth
  assign rd_addr = AW'(depth_q - (AW+1)'(2));

  // Coordinate storage, registered read of the new top
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      mem[0] <= wdata_i;
    end else if (cmd_i.push) begin
      mem[depth_q[AW-1:0]] <= wdata_i;
    end
    rdata_q <= mem[rd_addr];
  end

  // Depth counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else if (cmd_i.init) begin
      depth_q <= (AW+1)'(1);
    end else if (cmd_i.push) begin
      depth_q <= depth_q + (AW+1)'(1);
    end else if (cmd_i.pop) begin
      depth_q <= depth_q - (AW+1)'(1);
    end
  end

  assign rdata_o = rdata_q;
  assign depth_o = depth_q;

endmodule

@@ hw/rtl/grid_maze_dfs_path_search_core.sv @@
// Depth-first maze solver over a grid of cells held in on-chip memory.
// Command channel: a transfer happens when start is high and busy is low;
// op_i selects cell write, cell read or solve, with row_i/col_i/wall_i.
// Result channel: done_o pulses for one cycle with status_o, mark_o and
// path_length_o; the receiver cannot stall it and must take it then.
// Configuration: APB registers grid_height (0x0) and grid_width (0x4), pready
// tied high; the user must write them only while the block is idle, not enforced by the block.
// Timing: a cell write (or unused op) answers in the cycle after the transfer
// and a new command is taken in that cycle. A cell read answers from S_RDOUT,
// limited by the registered read port of the cell memory.
// A solve runs setup states S_INIT0, S_INIT1, then per visited cell S_TOP
// and S_CUR for the mark check, S_NB (S_NBCHK too if in grid) per neighbor probe,
// S_DEAD, S_POP per backtrack; all share one cell memory and one neighbor unit.
// Reset: the grid size returns to 21 x 41, the stack empties and the
// cursor goes to row 1, column 1; cell and stack memories are not cleared
// and a cell must be written before it is read or solved over.
module grid_maze_dfs_path_search_core #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [5:0]  row_i,
  input  logic [5:0]  col_i,
  input  logic        wall_i,
  // result channel
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [2:0]  mark_o,
  output logic [12:0] path_length_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam int unsigned AW = RW + CW;
  localparam int unsigned HW = $clog2(MAX_ROWS + 1);
  localparam int unsigned WW = $clog2(MAX_COLS + 1);
  localparam int unsigned CB = gmd_pkg::CFG_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDOUT,
    S_INIT0,
    S_INIT1,
    S_TOP,
    S_CUR,
    S_NB,
    S_NBCHK,
    S_DEAD,
    S_POP
  } state_e;

  state_e            state_q;
  logic              done_q;
  logic [1:0]        status_q;
  logic [2:0]        mark_q;
  logic [12:0]       plen_q;
  logic              rd_inside_q;
  logic [RW-1:0]     cur_row_q;
  logic [CW-1:0]     cur_col_q;
  gmd_pkg::dir_e     dir_q;
  logic [CB-1:0]     cfg_h_q;
  logic [CB-1:0]     cfg_w_q;

  logic              accept;
  logic              in_store;
  logic [RW-1:0]     in_row;
  logic [CW-1:0]     in_col;
  logic [HW-1:0]     height;
  logic [WW-1:0]     width;
  logic [RW-1:0]     goal_row;
  logic [CW-1:0]     goal_col;
  logic              at_goal;

  logic [RW-1:0]     nb_row;
  logic [CW-1:0]     nb_col;
  logic              nb_ok;

  logic              cs_we;
  logic [AW-1:0]     cs_waddr;
  logic [2:0]        cs_wdata;
  logic [AW-1:0]     cs_raddr;
  logic [2:0]        cs_rdata;
  logic              cs_open;

  gmd_pkg::stk_cmd_t stk_cmd;
  logic [AW-1:0]     stk_wdata;
  logic [AW-1:0]     stk_rdata;
  logic [AW:0]       stk_depth;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_h_q <= CB'(gmd_pkg::HEIGHT_RESET);
      cfg_w_q <= CB'(gmd_pkg::WIDTH_RESET);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == 1'(gmd_pkg::REG_WIDTH)) begin
        cfg_w_q <= pwdata[CB-1:0];
      end else begin
        cfg_h_q <= pwdata[CB-1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'(gmd_pkg::REG_WIDTH)) ? 32'(cfg_w_q) : 32'(cfg_h_q);

  // Clamp the grid size between MIN_DIM and what the memory holds
  always_comb begin
    if (32'(cfg_h_q) < gmd_pkg::MIN_DIM) begin
      height = HW'(gmd_pkg::MIN_DIM);
    end else if (32'(cfg_h_q) > MAX_ROWS) begin
      height = HW'(MAX_ROWS);
    end else begin
      height = HW'(cfg_h_q);
    end
    if (32'(cfg_w_q) < gmd_pkg::MIN_DIM) begin
      width = WW'(gmd_pkg::MIN_DIM);
    end else if (32'(cfg_w_q) > MAX_COLS) begin
      width = WW'(MAX_COLS);
    end else begin
      width = WW'(cfg_w_q);
    end
  end

  assign goal_row = RW'(height - HW'(1));
  assign goal_col = CW'(width - WW'(2));
  assign at_goal  = (cur_row_q == goal_row) && (cur_col_q == goal_col);

  // Command decode
  assign accept   = start && !busy;
  assign in_store = (32'(row_i) < MAX_ROWS) && (32'(col_i) < MAX_COLS);
  assign in_row   = RW'(row_i);
  assign in_col   = CW'(col_i);
  assign busy     = (state_q != S_IDLE);

  // Shared neighbor unit
  gmd_nbr_step #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_nbr (
    .cur_row_i (cur_row_q),
    .cur_col_i (cur_col_q),
    .dir_i     (dir_q),
    .height_i  (height),
    .width_i   (width),
    .nb_row_o  (nb_row),
    .nb_col_o  (nb_col),
    .nb_ok_o   (nb_ok)
  );

  gmd_cell_store #(
    .AW (AW)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (cs_we),
    .waddr_i (cs_waddr),
    .wdata_i (cs_wdata),
    .raddr_i (cs_raddr),
    .rdata_o (cs_rdata)
  );

  gmd_path_stack #(
    .AW (AW)
  ) u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (stk_cmd),
    .wdata_i (stk_wdata),
    .rdata_o (stk_rdata),
    .depth_o (stk_depth)
  );

  assign cs_open = (cs_rdata == gmd_pkg::MK_OPEN);

  // Memory port and stack control per sequencer step
  always_comb begin
    cs_we     = 1'b0;
    cs_waddr  = {cur_row_q, cur_col_q};
    cs_wdata  = gmd_pkg::MK_OPEN;
    cs_raddr  = {in_row, in_col};
    stk_cmd   = '0;
    stk_wdata = {cur_row_q, cur_col_q};
    unique case (state_q)
      S_IDLE: begin
        if (accept && (op_i == gmd_pkg::OP_WRITE) && in_store) begin
          cs_we    = 1'b1;
          cs_waddr = {in_row, in_col};
          cs_wdata = wall_i ? gmd_pkg::MK_WALL : gmd_pkg::MK_OPEN;
        end
      end
      S_INIT0: begin
        cs_we        = 1'b1;
        cs_waddr     = {RW'(0), CW'(1)};
        cs_wdata     = gmd_pkg::MK_ENTR;
        stk_cmd.init = 1'b1;
        stk_wdata    = {RW'(0), CW'(1)};
      end
      S_INIT1: begin
        cs_we    = 1'b1;
        cs_waddr = {goal_row, goal_col};
        cs_wdata = gmd_pkg::MK_OPEN;
      end
      S_TOP: begin
        cs_raddr = {cur_row_q, cur_col_q};
      end
      S_CUR: begin
        if (cs_open) begin
          cs_we        = 1'b1;
          cs_wdata     = gmd_pkg::MK_PATH;
          stk_cmd.push = 1'b1;
        end
      end
      S_NB: begin
        cs_raddr = {nb_row, nb_col};
      end
      S_DEAD: begin
        cs_we       = 1'b1;
        cs_wdata    = gmd_pkg::MK_DEAD;
        stk_cmd.pop = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer with registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_q      <= 1'b0;
      status_q    <= gmd_pkg::ST_DONE;
      mark_q      <= gmd_pkg::MK_OPEN;
      plen_q      <= '0;
      rd_inside_q <= 1'b0;
      cur_row_q   <= RW'(1);
      cur_col_q   <= CW'(1);
      dir_q       <= gmd_pkg::DIR_UP;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            status_q <= gmd_pkg::ST_DONE;
            mark_q   <= gmd_pkg::MK_OPEN;
            plen_q   <= '0;
            case (op_i)
              gmd_pkg::OP_READ: begin
                rd_inside_q <= in_store;
                state_q     <= S_RDOUT;
              end
              gmd_pkg::OP_SOLVE: begin
                cur_row_q <= RW'(1);
                cur_col_q <= CW'(1);
                state_q   <= S_INIT0;
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end
        S_RDOUT: begin
          done_q  <= 1'b1;
          mark_q  <= rd_inside_q ? cs_rdata : gmd_pkg::MK_WALL;
          state_q <= S_IDLE;
        end
        S_INIT0: begin
          state_q <= S_INIT1;
        end
        S_INIT1: begin
          state_q <= S_TOP;
        end
        S_TOP: begin
          if (at_goal) begin
            done_q   <= 1'b1;
            status_q <= gmd_pkg::ST_FOUND;
            plen_q   <= 13'(stk_depth);
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_CUR;
          end
        end
        S_CUR: begin
          dir_q   <= gmd_pkg::DIR_UP;
          state_q <= S_NB;
        end
        S_NB: begin
          if (nb_ok) begin
            state_q <= S_NBCHK;
          end else if (dir_q == gmd_pkg::DIR_LEFT) begin
            state_q <= S_DEAD;
          end else begin
            dir_q <= gmd_pkg::dir_e'(dir_q + 2'd1);
          end
        end
        S_NBCHK: begin
          if (cs_open) begin
            cur_row_q <= nb_row;
            cur_col_q <= nb_col;
            state_q   <= S_TOP;
          end else if (dir_q == gmd_pkg::DIR_LEFT) begin
            state_q <= S_DEAD;
          end else begin
            dir_q   <= gmd_pkg::dir_e'(dir_q + 2'd1);
            state_q <= S_NB;
          end
        end
        S_DEAD: begin
          // popping the last entry ends the walk with no path
          if (stk_depth == (AW+1)'(1)) begin
            done_q   <= 1'b1;
            status_q <= gmd_pkg::ST_NOPATH;
            plen_q   <= '0;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_POP;
          end
        end
        S_POP: begin
          cur_row_q <= stk_rdata[AW-1:CW];
          cur_col_q <= stk_rdata[CW-1:0];
          state_q   <= S_TOP;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign mark_o        = mark_q;
  assign path_length_o = plen_q;

endmodule

@@ hw/rtl/gmd_checker.sv @@
module gmd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  op_i,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [12:0] path_length_o
);

  // A cell write answers in the next cycle with done status
  a_write_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (op_i == gmd_pkg::OP_WRITE)
    |=> done_o && (status_o == gmd_pkg::ST_DONE))
    else $error("cell write did not answer in one cycle");

  // A cell read answers after the cell memory's registered read and the result register
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (op_i == gmd_pkg::OP_READ)
    |-> ##2 done_o && (status_o == gmd_pkg::ST_DONE))
    else $error("cell read did not answer in two cycles");

  // After a transfer the block is either working or answering
  a_accept_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("command transfer dropped");

  // Only a found path carries a length, and it is never empty
  a_path_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((status_o == gmd_pkg::ST_FOUND) == (path_length_o != '0)))
    else $error("path length inconsistent with status");

endmodule

bind grid_maze_dfs_path_search_core gmd_checker u_gmd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .op_i          (op_i),
  .done_o        (done_o),
  .status_o      (status_o),
  .path_length_o (path_length_o)
);
